/* rtl/u8u16_pkg.sv */
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [15:0] CapacityReset = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_UNIT  = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // one queued record: one or two result items
  typedef struct packed {
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    status_e     status;
    logic        stored;
    logic [15:0] total_a;
    logic [15:0] total_b;
    logic        pair;
  } u8u16_rec_t;

endpackage

/* rtl/utf8_to_utf16_transcoder_unit.sv */
// top level of the utf-8 to utf-16 transcoder
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o  | utf8_byte_i
//   out     | output    | out_valid_o/out_ready_i| code_unit_o, status_o,
//           |           |                        | stored_o, unit_total_o,
//           |           |                        | run_last_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (out_capacity)
//
// one byte is taken per cycle; the decoder settles each byte in the cycle it
// is taken and queues at most one record for it
// the output register gives one item per cycle while out_ready_i is high, and a
// surrogate pair gives two items, so the output side sets the sustained rate
// in_ready_o drops only while the four-entry record queue is full
// reset clears the decoder state and count, and sets the capacity to 65535
module utf8_to_utf16_transcoder_unit import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  utf8_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic [1:0]  status_o,
  output logic        stored_o,
  output logic [15:0] unit_total_o,
  output logic        run_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // record path between front end, queue and output stage
  u8u16_rec_t push_rec;
  u8u16_rec_t head_rec;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  // decoder, capacity register and unit count
  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .utf8_byte_i (utf8_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // decouples decoding from the output handshake
  u8u16_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // splits pairs into two items and drives the output
  u8u16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (head_rec),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_unit_o  (code_unit_o),
    .status_o     (status_o),
    .stored_o     (stored_o),
    .unit_total_o (unit_total_o),
    .run_last_o   (run_last_o)
  );

endmodule

/* rtl/u8u16_front.sv */
// front end: accepts bytes, decodes utf-8, counts units and builds records
module u8u16_front import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  utf8_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        q_full_i,
  output logic        push_o,
  output u8u16_rec_t  rec_o
);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_FAIL,
    ACT_FAIL_END,
    ACT_END,
    ACT_RESTART
  } act_e;

  logic [1:0]  pend_q, pend_d;
  logic [7:0]  lead_q, lead_d;
  logic [20:0] part_q, part_d;
  logic [15:0] count_q, count_d;
  logic        disc_q, disc_d;
  logic [15:0] cap_q;

  logic        accept;
  act_e        act;
  logic [1:0]  acc_pend;
  logic [7:0]  acc_lead;
  logic [20:0] acc_part;
  logic [20:0] code;
  logic        first_cont;
  logic        is_pair;
  logic [16:0] sum_n;

  assign accept      = in_valid_i & in_ready_o;
  assign in_ready_o  = ~q_full_i;
  assign cfg_ready_o = 1'b1;

  // classify the byte against the sequence in progress
  always_comb begin
    act        = ACT_NONE;
    acc_pend   = pend_q;
    acc_lead   = lead_q;
    acc_part   = part_q;
    code       = {13'd0, utf8_byte_i};
    first_cont = ((lead_q >= 8'hE0) && (lead_q < 8'hF0) && (pend_q == 2'd2)) ||
                 ((lead_q >= 8'hF0) && (pend_q == 2'd3));
    if (utf8_byte_i == 8'h00) begin
      if (disc_q) begin
        act = ACT_RESTART;
      end else if (pend_q != 2'd0) begin
        act = ACT_FAIL_END;
      end else begin
        act = ACT_END;
      end
    end else if (disc_q) begin
      act = ACT_NONE;
    end else if (pend_q == 2'd0) begin
      if (utf8_byte_i < 8'h80) begin
        act = ACT_EMIT;
      end else if ((utf8_byte_i < 8'hC2) || (utf8_byte_i >= 8'hF5)) begin
        act = ACT_FAIL;
      end else begin
        acc_lead = utf8_byte_i;
        if (utf8_byte_i < 8'hE0) begin
          acc_pend = 2'd1;
          acc_part = {16'd0, utf8_byte_i[4:0]};
        end else if (utf8_byte_i < 8'hF0) begin
          acc_pend = 2'd2;
          acc_part = {17'd0, utf8_byte_i[3:0]};
        end else begin
          acc_pend = 2'd3;
          acc_part = {18'd0, utf8_byte_i[2:0]};
        end
      end
    end else if (utf8_byte_i[7:6] != 2'b10) begin
      act = ACT_FAIL;
    end else if (first_cont && (((lead_q == 8'hE0) && (utf8_byte_i < 8'hA0)) ||
                                ((lead_q == 8'hF0) && (utf8_byte_i < 8'h90)) ||
                                ((lead_q == 8'hF4) && (utf8_byte_i >= 8'h90)))) begin
      act = ACT_FAIL;
    end else begin
      acc_part = {part_q[14:0], utf8_byte_i[5:0]};
      acc_pend = pend_q - 2'd1;
      code     = acc_part;
      if (acc_pend == 2'd0) begin
        act = ACT_EMIT;
      end
    end
  end

  assign is_pair = (code >= 21'h10000);
  assign sum_n   = {1'b0, count_q} + (is_pair ? 17'd2 : 17'd1);

  // resolve the action into next state and a record
  always_comb begin
    pend_d        = acc_pend;
    lead_d        = acc_lead;
    part_d        = acc_part;
    count_d       = count_q;
    disc_d        = disc_q;
    push_o        = 1'b0;
    rec_o.unit_a  = code[15:0];
    rec_o.unit_b  = 16'((code & 21'h3FF) + 21'hDC00);
    rec_o.status  = ST_UNIT;
    rec_o.stored  = 1'b0;
    rec_o.total_a = count_q + 16'd1;
    rec_o.total_b = count_q + 16'd2;
    rec_o.pair    = 1'b0;
    case (act)
      ACT_EMIT: begin
        pend_d = 2'd0;
        lead_d = 8'd0;
        part_d = 21'd0;
        push_o = 1'b1;
        if (code >= 21'h110000) begin
          rec_o.status  = ST_ERROR;
          rec_o.unit_a  = 16'd0;
          rec_o.total_a = count_q;
          disc_d        = 1'b1;
        end else if (sum_n[16]) begin
          // count would pass its ceiling
          rec_o.status  = ST_ERROR;
          rec_o.unit_a  = 16'd0;
          rec_o.total_a = 16'hFFFF;
          count_d       = 16'hFFFF;
          disc_d        = 1'b1;
        end else begin
          rec_o.stored = (sum_n <= {1'b0, cap_q});
          rec_o.pair   = is_pair;
          if (is_pair) begin
            rec_o.unit_a = 16'((code >> 10) + 21'hD7C0);
          end
          count_d = sum_n[15:0];
        end
      end
      ACT_FAIL: begin
        pend_d        = 2'd0;
        lead_d        = 8'd0;
        part_d        = 21'd0;
        disc_d        = 1'b1;
        push_o        = 1'b1;
        rec_o.status  = ST_ERROR;
        rec_o.unit_a  = 16'd0;
        rec_o.total_a = count_q;
      end
      ACT_FAIL_END: begin
        pend_d        = 2'd0;
        lead_d        = 8'd0;
        part_d        = 21'd0;
        disc_d        = 1'b0;
        count_d       = 16'd0;
        push_o        = 1'b1;
        rec_o.status  = ST_ERROR;
        rec_o.unit_a  = 16'd0;
        rec_o.total_a = count_q;
      end
      ACT_END: begin
        count_d       = 16'd0;
        push_o        = 1'b1;
        rec_o.status  = ST_END;
        rec_o.unit_a  = 16'd0;
        rec_o.total_a = count_q;
      end
      ACT_RESTART: begin
        pend_d  = 2'd0;
        lead_d  = 8'd0;
        part_d  = 21'd0;
        disc_d  = 1'b0;
        count_d = 16'd0;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    if (!accept) begin
      push_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 2'd0;
      lead_q  <= 8'd0;
      part_q  <= 21'd0;
      count_q <= 16'd0;
      disc_q  <= 1'b0;
      cap_q   <= CapacityReset;
    end else begin
      if (accept) begin
        pend_q  <= pend_d;
        lead_q  <= lead_d;
        part_q  <= part_d;
        count_q <= count_d;
        disc_q  <= disc_d;
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

endmodule

/* rtl/u8u16_queue.sv */
// short record queue between the decoder and the output stage
module u8u16_queue import u8u16_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  u8u16_rec_t rec_i,
  input  logic       pop_i,
  output u8u16_rec_t rec_o,
  output logic       full_o,
  output logic       empty_o
);

  u8u16_rec_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? QueuePtrW'((QueueDepth == (1 << QueuePtrW)) ? wr_q + 1'b1 :
            ((wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1)) : wr_q;
    rd_d  = pop_i ? QueuePtrW'((QueueDepth == (1 << QueuePtrW)) ? rd_q + 1'b1 :
            ((rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1)) : rd_q;
    cnt_d = cnt_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/u8u16_back.sv */
// back end: output register that plays out one or two items per record
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  u8u16_rec_t  rec_i,
  input  logic        q_empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic [1:0]  status_o,
  output logic        stored_o,
  output logic [15:0] unit_total_o,
  output logic        run_last_o
);

  u8u16_rec_t rec_q;
  logic       hold_q, hold_d;
  logic       phase_q, phase_d;
  logic       last;
  logic       done;

  assign last  = ~rec_q.pair | phase_q;
  assign done  = hold_q & out_ready_i & last;
  assign pop_o = ~q_empty_i & (~hold_q | done);

  always_comb begin
    hold_d  = hold_q;
    phase_d = phase_q;
    if (pop_o) begin
      hold_d  = 1'b1;
      phase_d = 1'b0;
    end else if (done) begin
      hold_d  = 1'b0;
      phase_d = 1'b0;
    end else if (hold_q && out_ready_i) begin
      phase_d = 1'b1;
    end
  end

  assign out_valid_o  = hold_q;
  assign code_unit_o  = phase_q ? rec_q.unit_b : rec_q.unit_a;
  assign status_o     = rec_q.status;
  assign stored_o     = rec_q.stored;
  assign unit_total_o = phase_q ? rec_q.total_b : rec_q.total_a;
  assign run_last_o   = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      hold_q  <= hold_d;
      phase_q <= phase_d;
    end
  end

endmodule
